>>> src/itprt_pkg.sv
// ----------------------------------------------------------------------------
// itprt_pkg
// Shared types, codes and helpers for the power-of-two radix text converter.
// ----------------------------------------------------------------------------
package itprt_pkg;

	localparam logic [7:0] CH_MINUS       = 8'h2D;   // '-'
	localparam logic [7:0] CH_ZERO        = 8'h30;   // '0'
	localparam logic [7:0] CH_LETTER_A    = 8'h41;   // 'A'
	localparam logic [2:0] DIGIT_BITS_MIN = 3'd1;
	localparam logic [2:0] DIGIT_BITS_MAX = 3'd5;
	localparam logic [4:0] DECIMAL_LIMIT  = 5'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ERR,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic emit_sign;
		logic emit_digit;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic bits_ok;
		logic neg;
		logic top_zero;
		logic cnt_one;
		logic out_free;
	} status_t;

	function automatic logic [7:0] digit_char(input logic [4:0] d);
		logic [7:0] d8;
		d8 = {3'b000, d};
		if (d < DECIMAL_LIMIT) begin
			return CH_ZERO + d8;
		end
		return CH_LETTER_A + d8 - {3'b000, DECIMAL_LIMIT};
	endfunction

endpackage

>>> src/itprt_req_if.sv
// ----------------------------------------------------------------------------
// itprt_req_if
// Request channel: value to convert and its digit width.
// ----------------------------------------------------------------------------
interface itprt_req_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;
	logic [2:0]             digit_bits;

	modport source (output valid, output value, output digit_bits, input ready);
	modport sink (input valid, input value, input digit_bits, output ready);
endinterface

>>> src/itprt_res_if.sv
// ----------------------------------------------------------------------------
// itprt_res_if
// Result channel: one character of the converted text per transfer.
// ----------------------------------------------------------------------------
interface itprt_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       status;
	logic       last;

	modport source (output valid, output character, output status, output last, input ready);
	modport sink (input valid, input character, input status, input last, output ready);
endinterface

>>> src/itprt_ctrl.sv
// ----------------------------------------------------------------------------
// itprt_ctrl
// Sequencer: load, skip leading zero digits, emit sign and digits, or an error result.
// ----------------------------------------------------------------------------
module itprt_ctrl
	import itprt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!status.bits_ok) begin
					state_d = ST_ERR;
				end else if (!(status.top_zero && !status.cnt_one)) begin
					state_d = status.neg ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SIGN: begin
				if (status.out_free) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (status.out_free && status.cnt_one) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_SCAN: begin
				// drop a leading zero digit, but always keep the last slot
				cmd.shift = status.bits_ok && status.top_zero && !status.cnt_one;
			end
			ST_ERR: begin
				cmd.emit_err = status.out_free;
			end
			ST_SIGN: begin
				cmd.emit_sign = status.out_free;
			end
			ST_DIGIT: begin
				cmd.emit_digit = status.out_free;
				cmd.shift      = status.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> src/itprt_dp.sv
// ----------------------------------------------------------------------------
// itprt_dp
// Datapath: magnitude shift register, digit slot counter, output register.
// ----------------------------------------------------------------------------
module itprt_dp
	import itprt_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [2:0]             digit_bits,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [7:0]             character,
	output logic                   res_status,
	output logic                   last
);

	// four spare bits so every digit slot count lines up with the top
	localparam int SW = VALUE_WIDTH + 4;
	localparam int CW = $clog2(VALUE_WIDTH + 1);
	localparam int N1 = VALUE_WIDTH;
	localparam int N2 = (VALUE_WIDTH + 1) / 2;
	localparam int N3 = (VALUE_WIDTH + 2) / 3;
	localparam int N4 = (VALUE_WIDTH + 3) / 4;
	localparam int N5 = (VALUE_WIDTH + 4) / 5;
	localparam int SH1 = SW - N1;
	localparam int SH2 = SW - 2 * N2;
	localparam int SH3 = SW - 3 * N3;
	localparam int SH4 = SW - 4 * N4;
	localparam int SH5 = SW - 5 * N5;

	logic [SW-1:0]          sr_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic [2:0]             bits_q;
	logic [7:0]             char_q;
	logic                   status_q;
	logic                   last_q;
	logic                   valid_q;

	logic [VALUE_WIDTH-1:0] mag;
	logic [SW-1:0]          mag_ext;
	logic [SW-1:0]          sr_load;
	logic [CW-1:0]          cnt_load;
	logic [SW-1:0]          sr_next;
	logic [4:0]             top5;
	logic [4:0]             digit;
	logic [2:0]             drop;
	logic                   out_free;

	// two's complement negate; the most negative value lands on 2^(W-1)
	assign mag     = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
	assign mag_ext = SW'(mag);

	always_comb begin
		case (digit_bits)
			3'd1: begin
				sr_load  = mag_ext << SH1;
				cnt_load = CW'(N1);
			end
			3'd2: begin
				sr_load  = mag_ext << SH2;
				cnt_load = CW'(N2);
			end
			3'd3: begin
				sr_load  = mag_ext << SH3;
				cnt_load = CW'(N3);
			end
			3'd4: begin
				sr_load  = mag_ext << SH4;
				cnt_load = CW'(N4);
			end
			3'd5: begin
				sr_load  = mag_ext << SH5;
				cnt_load = CW'(N5);
			end
			default: begin
				sr_load  = mag_ext;
				cnt_load = CW'(1);
			end
		endcase
	end

	always_comb begin
		case (bits_q)
			3'd1:    sr_next = sr_q << 1;
			3'd2:    sr_next = sr_q << 2;
			3'd3:    sr_next = sr_q << 3;
			3'd4:    sr_next = sr_q << 4;
			3'd5:    sr_next = sr_q << 5;
			default: sr_next = sr_q;
		endcase
	end

	assign top5  = sr_q[SW-1 -: 5];
	assign drop  = DIGIT_BITS_MAX - bits_q;
	assign digit = top5 >> drop;

	assign out_free        = !valid_q || res_ready;
	assign status.bits_ok  = (bits_q >= DIGIT_BITS_MIN) && (bits_q <= DIGIT_BITS_MAX);
	assign status.neg      = neg_q;
	assign status.top_zero = (digit == 5'd0);
	assign status.cnt_one  = (cnt_q == CW'(1));
	assign status.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sr_q   <= sr_load;
			cnt_q  <= cnt_load;
			neg_q  <= value[VALUE_WIDTH-1];
			bits_q <= digit_bits;
		end else if (cmd.shift) begin
			sr_q  <= sr_next;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			char_q   <= 8'd0;
			status_q <= 1'b1;
			last_q   <= 1'b1;
		end else if (cmd.emit_sign) begin
			char_q   <= CH_MINUS;
			status_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q   <= digit_char(digit);
			status_q <= 1'b0;
			last_q   <= status.cnt_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign res_valid  = valid_q;
	assign character  = char_q;
	assign res_status = status_q;
	assign last       = last_q;

endmodule

>>> src/int_to_pow2_radix_text_top.sv
// ----------------------------------------------------------------------------
// int_to_pow2_radix_text_top
// Signed integer to ASCII text in radix 2, 4, 8, 16 or 32.
// ----------------------------------------------------------------------------
// One request carries a signed VALUE_WIDTH-bit value and a digit width of 1
// to 5 bits; the block returns the text one character per result, most
// significant digit first, with a leading '-' for negative values and
// digits 0-9 then A-V. Zero gives '0'; the most negative value is printed as
// the magnitude 2^(VALUE_WIDTH-1). A digit width of 0, 6 or 7 gives a single
// result with status 1, character 0 and last set. Requests are taken one at
// a time. The magnitude shift register holds ceil(VALUE_WIDTH / digit_bits)
// digit slots and moves one digit slot per cycle, first over the leading
// zero digits and then once per emitted character, where output back
// pressure can hold it; the last character sits in the output register
// while the next request is taken.
module int_to_pow2_radix_text_top
	import itprt_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	itprt_req_if.sink     request,
	itprt_res_if.source   result
);

	cmd_t    cmd;
	status_t status;

	itprt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.status    (status),
		.cmd       (cmd)
	);

	itprt_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.value      (request.value),
		.digit_bits (request.digit_bits),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.character  (result.character),
		.res_status (result.status),
		.last       (result.last)
	);

endmodule

>>> src/itprt_chk.sv
// ----------------------------------------------------------------------------
// itprt_chk
// Port-level checks for the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
module itprt_chk
	import itprt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] character,
	input logic       status,
	input logic       last
);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(character)
			&& $stable(status) && $stable(last))
		else $error("stalled result changed");

	// one request at a time: no new request right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status |-> last && (character == 8'd0))
		else $error("invalid-width result malformed");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !status |-> (character == CH_MINUS)
			|| ((character >= CH_ZERO) && (character <= 8'h39))
			|| ((character >= CH_LETTER_A) && (character <= 8'h56)))
		else $error("character outside the digit set");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (character == CH_MINUS) |-> !last && !status)
		else $error("minus sign ended a conversion");

endmodule

bind int_to_pow2_radix_text_top itprt_chk u_itprt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.character (result.character),
	.status    (result.status),
	.last      (result.last)
);
